// ===== src/tmf_pkg.sv =====
// Shared constants and types for the multichannel trimmed mean filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tmf_pkg;

  localparam int SAMPLE_BITS      = 12;
  localparam int VALUE_BITS       = 12;
  localparam int CHAN_BITS        = 3;
  localparam int CFG_BITS         = 3;
  localparam int MAX_CHANNELS_DEF = 6;
  localparam int SAMPLES_DEF      = 8;

  localparam logic [CFG_BITS-1:0] CFG_RESET = 3'd6;

  typedef struct packed {
    logic vld;
    logic frame_end;
  } tmf_ctl_t;

endpackage

`default_nettype wire

// ===== src/multichannel_trimmed_mean_filter.sv =====
// Top level of the multichannel trimmed mean filter: ports, channel count register,
// input skid stage and input register. Depends on tmf_pkg, tmf_stats and tmf_div.
//
//   Channel  Direction  Handshake                 Payload
//   in       sink       in_valid_i / in_stall_o   sample_i, frame_start_i
//   out      source     out_valid_o / out_stall_i channel_o, value_o, frame_end_o
//   cfg      sink       cfg_valid_i / cfg_ready_o cfg_data_i (channels in use)
//
// A sample beat is taken every cycle while in_stall_o is low, then passes the input,
// stats and result registers. The per-channel min, max and sum registers set that rate.
// Reset clears the counters to channel 0 of round 0 and sets the channel count to six.
// An output stall freezes the pipeline; one skid entry keeps in_stall_o registered.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_trimmed_mean_filter #(
  parameter int MAX_CHANNELS = tmf_pkg::MAX_CHANNELS_DEF,
  parameter int SAMPLES = tmf_pkg::SAMPLES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [tmf_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                            frame_start_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [tmf_pkg::CHAN_BITS-1:0]   channel_o,
  output logic [tmf_pkg::VALUE_BITS-1:0]  value_o,
  output logic                            frame_end_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tmf_pkg::CFG_BITS-1:0]    cfg_data_i
);
  import tmf_pkg::*;

  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SUM_W = SAMPLE_BITS + $clog2(SAMPLES);

  logic [CFG_BITS-1:0]    cfg_q;
  logic [CH_W:0]          chans;

  logic                   skid_vld_q, skid_vld_d;
  logic [SAMPLE_BITS-1:0] skid_sample_q;
  logic                   skid_start_q;
  logic                   s0_vld_q, s0_vld_d;
  logic [SAMPLE_BITS-1:0] s0_sample_q;
  logic                   s0_start_q;

  logic                   accept;
  logic                   adv;
  logic                   s0_ready;

  tmf_ctl_t               s1_ctl;
  logic [CH_W-1:0]        s1_ch;
  logic [SUM_W-1:0]       s1_rest;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (cfg_q == '0) begin
      chans = (CH_W + 1)'(1);
    end else if (32'(cfg_q) > MAX_CHANNELS) begin
      chans = (CH_W + 1)'(MAX_CHANNELS);
    end else begin
      chans = (CH_W + 1)'(cfg_q);
    end
  end

  always_comb begin
    adv        = !out_valid_o || !out_stall_i;
    s0_ready   = adv || !s0_vld_q;
    in_stall_o = skid_vld_q;
    accept     = in_valid_i && !skid_vld_q;

    skid_vld_d = skid_vld_q;
    s0_vld_d   = s0_vld_q;
    if (s0_ready) begin
      skid_vld_d = 1'b0;
      s0_vld_d   = skid_vld_q || accept;
    end else if (accept) begin
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
      s0_vld_q   <= 1'b0;
    end else begin
      skid_vld_q <= skid_vld_d;
      s0_vld_q   <= s0_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !s0_ready) begin
      skid_sample_q <= sample_i;
      skid_start_q  <= frame_start_i;
    end
    if (s0_ready) begin
      if (skid_vld_q) begin
        s0_sample_q <= skid_sample_q;
        s0_start_q  <= skid_start_q;
      end else begin
        s0_sample_q <= sample_i;
        s0_start_q  <= frame_start_i;
      end
    end
  end

  tmf_stats #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLES      (SAMPLES)
  ) u_stats (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .vld_i    (s0_vld_q),
    .sample_i (s0_sample_q),
    .start_i  (s0_start_q),
    .chans_i  (chans),
    .ctl_o    (s1_ctl),
    .ch_o     (s1_ch),
    .rest_o   (s1_rest)
  );

  tmf_div #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLES      (SAMPLES)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .ctl_i       (s1_ctl),
    .ch_i        (s1_ch),
    .rest_i      (s1_rest),
    .valid_o     (out_valid_o),
    .channel_o   (channel_o),
    .value_o     (value_o),
    .frame_end_o (frame_end_o)
  );

  a_skid_behind_s0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> s0_vld_q)
    else $error("skid entry held while the input register is empty");

  a_stall_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i))
    else $error("input stall raised without an incoming beat");

  a_stall_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |=> !in_stall_o)
    else $error("input stall held although the output was free");

endmodule

`default_nettype wire

// ===== src/tmf_stats.sv =====
// Channel and round counters plus per-channel minimum, maximum and sum registers.
// Produces the trimmed sum of a channel on its last round. Depends on tmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmf_stats #(
  parameter int MAX_CHANNELS = tmf_pkg::MAX_CHANNELS_DEF,
  parameter int SAMPLES = tmf_pkg::SAMPLES_DEF,
  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int RND_W = $clog2(SAMPLES),
  localparam int SUM_W = tmf_pkg::SAMPLE_BITS + $clog2(SAMPLES)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             adv_i,
  input  logic                             vld_i,
  input  logic [tmf_pkg::SAMPLE_BITS-1:0]  sample_i,
  input  logic                             start_i,
  input  logic [CH_W:0]                    chans_i,
  output tmf_pkg::tmf_ctl_t                ctl_o,
  output logic [CH_W-1:0]                  ch_o,
  output logic [SUM_W-1:0]                 rest_o
);
  import tmf_pkg::*;

  logic [SAMPLE_BITS-1:0] min_q [MAX_CHANNELS];
  logic [SAMPLE_BITS-1:0] max_q [MAX_CHANNELS];
  logic [SUM_W-1:0]       sum_q [MAX_CHANNELS];

  logic [CH_W-1:0]        chan_pos_q, chan_pos_d;
  logic [RND_W-1:0]       round_pos_q, round_pos_d;
  tmf_ctl_t               ctl_q, ctl_d;
  logic [CH_W-1:0]        ch_q;
  logic [SUM_W-1:0]       rest_q, rest_d;

  logic                   en;
  logic                   restart;
  logic [CH_W-1:0]        ch;
  logic [RND_W-1:0]       rnd;
  logic                   first;
  logic                   last_round;
  logic [CH_W:0]          ch_next;
  logic [SAMPLE_BITS-1:0] min_d, max_d;
  logic [SUM_W-1:0]       sum_d;

  always_comb begin
    en         = vld_i & adv_i;
    restart    = start_i || ({1'b0, chan_pos_q} >= chans_i) || (32'(round_pos_q) >= SAMPLES);
    ch         = restart ? '0 : chan_pos_q;
    rnd        = restart ? '0 : round_pos_q;
    first      = (rnd == '0);
    last_round = (rnd == RND_W'(SAMPLES - 1));

    min_d = (first || (sample_i < min_q[ch])) ? sample_i : min_q[ch];
    max_d = (first || (sample_i > max_q[ch])) ? sample_i : max_q[ch];
    sum_d = first ? SUM_W'(sample_i) : sum_q[ch] + SUM_W'(sample_i);
    rest_d = sum_d - SUM_W'(min_d) - SUM_W'(max_d);

    ch_next         = {1'b0, ch} + (CH_W + 1)'(1);
    ctl_d.vld       = vld_i & last_round;
    ctl_d.frame_end = (ch_next == chans_i);

    chan_pos_d  = chan_pos_q;
    round_pos_d = round_pos_q;
    if (en) begin
      if (ch_next >= chans_i) begin
        chan_pos_d  = '0;
        round_pos_d = last_round ? '0 : rnd + RND_W'(1);
      end else begin
        chan_pos_d  = ch_next[CH_W-1:0];
        round_pos_d = rnd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      min_q[ch] <= min_d;
      max_q[ch] <= max_d;
      sum_q[ch] <= sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_pos_q  <= '0;
      round_pos_q <= '0;
      ctl_q       <= '0;
    end else begin
      chan_pos_q  <= chan_pos_d;
      round_pos_q <= round_pos_d;
      if (adv_i) begin
        ctl_q <= ctl_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ch_q   <= ch;
      rest_q <= rest_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign ch_o   = ch_q;
  assign rest_o = rest_q;

  a_chan_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(chan_pos_q) < MAX_CHANNELS)
    else $error("channel position beyond the channel store");

  a_round_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(round_pos_q) < SAMPLES)
    else $error("round position beyond the frame length");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && last_round && ctl_d.frame_end) |=> (chan_pos_q == '0) && (round_pos_q == '0))
    else $error("counters did not wrap at the end of a frame");

endmodule

`default_nettype wire

// ===== src/tmf_div.sv =====
// Floor division of the trimmed sum by the sample count minus two, and the result register.
// Uses a reciprocal multiply with a rounded-up constant. Depends on tmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmf_div #(
  parameter int MAX_CHANNELS = tmf_pkg::MAX_CHANNELS_DEF,
  parameter int SAMPLES = tmf_pkg::SAMPLES_DEF,
  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int SUM_W = tmf_pkg::SAMPLE_BITS + $clog2(SAMPLES)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  tmf_pkg::tmf_ctl_t               ctl_i,
  input  logic [CH_W-1:0]                 ch_i,
  input  logic [SUM_W-1:0]                rest_i,
  output logic                            valid_o,
  output logic [tmf_pkg::CHAN_BITS-1:0]   channel_o,
  output logic [tmf_pkg::VALUE_BITS-1:0]  value_o,
  output logic                            frame_end_o
);
  import tmf_pkg::*;

  localparam int DIVISOR = SAMPLES - 2;
  localparam int SHIFT   = SUM_W + $clog2(DIVISOR);
  localparam int MUL_W   = SUM_W + 1;
  localparam int PROD_W  = SUM_W + MUL_W;
  localparam longint unsigned MUL_K =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [MUL_W-1:0] MUL_C = MUL_W'(MUL_K);

  logic [PROD_W-1:0]     prod;
  logic [VALUE_BITS-1:0] value_d;
  logic                  vld_q;
  logic [CHAN_BITS-1:0]  channel_q;
  logic [VALUE_BITS-1:0] value_q;
  logic                  frame_end_q;

  always_comb begin
    prod    = PROD_W'(rest_i) * PROD_W'(MUL_C);
    value_d = VALUE_BITS'(prod >> SHIFT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      channel_q   <= CHAN_BITS'(ch_i);
      value_q     <= value_d;
      frame_end_q <= ctl_i.frame_end;
    end
  end

  assign valid_o     = vld_q;
  assign channel_o   = channel_q;
  assign value_o     = value_q;
  assign frame_end_o = frame_end_q;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for multichannel_trimmed_mean_filter with a scoreboard class.
// Depends on tmf_pkg and the filter RTL; drives samples, channel count writes and output stalls.
`timescale 1ns / 1ps

module testbench;
  import tmf_pkg::*;

  localparam int SAMPLES        = SAMPLES_DEF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TOTAL_SAMPLES  = 1850;
  localparam int HOLD_CYCLES    = 250;

  typedef struct packed {
    logic [CHAN_BITS-1:0]  channel;
    logic [VALUE_BITS-1:0] value;
    logic                  frame_end;
  } filt_result_t;

  class trimmed_mean_scoreboard;
    logic [CFG_BITS-1:0]         chan_cfg;
    logic [SAMPLE_BITS-1:0]      lo [MAX_CHANNELS_DEF];
    logic [SAMPLE_BITS-1:0]      hi [MAX_CHANNELS_DEF];
    logic [14:0]                 acc [MAX_CHANNELS_DEF];
    logic [MAX_CHANNELS_DEF-1:0] seen;
    int unsigned                 pos;
    int unsigned                 rnd;
    int unsigned                 errors;
    filt_result_t                expected_means [$];

    function new();
      chan_cfg = CFG_RESET;
      seen = '0;
      pos = 0;
      rnd = 0;
      errors = 0;
      foreach (lo[i]) begin
        lo[i] = '0;
        hi[i] = '0;
        acc[i] = '0;
      end
    endfunction

    function int unsigned active();
      if (chan_cfg == 0) return 1;
      if (chan_cfg > MAX_CHANNELS_DEF) return MAX_CHANNELS_DEF;
      return chan_cfg;
    endfunction

    function void set_channels(logic [CFG_BITS-1:0] v);
      chan_cfg = v;
    endfunction

    function bit restarts(logic fs);
      return fs || pos >= active() || rnd >= SAMPLES;
    endfunction

    function int unsigned next_channel(logic fs);
      return restarts(fs) ? 0 : pos;
    endfunction

    function bit frame_edge();
      return restarts(1'b0) || (pos == 0 && rnd == 0);
    endfunction

    // A later round must never land on a channel that round 0 of this frame skipped.
    function bit unsafe();
      if (restarts(1'b0)) return 0;
      return rnd > 0 && !seen[pos];
    endfunction

    function int pending();
      return expected_means.size();
    endfunction

    function void note_sample(logic [SAMPLE_BITS-1:0] s, logic fs);
      int unsigned  n;
      int unsigned  ch;
      logic [14:0]  rest;
      filt_result_t r;
      n = active();
      if (restarts(fs)) begin
        pos = 0;
        rnd = 0;
      end
      ch = pos;
      if (rnd == 0) begin
        if (ch == 0) seen = '0;
        seen[ch] = 1'b1;
        lo[ch] = s;
        hi[ch] = s;
        acc[ch] = 15'(s);
      end else begin
        if (s < lo[ch]) lo[ch] = s;
        if (s > hi[ch]) hi[ch] = s;
        acc[ch] = acc[ch] + 15'(s);
      end
      if (rnd == SAMPLES - 1) begin
        rest = acc[ch] - 15'(lo[ch]) - 15'(hi[ch]);
        r.channel = CHAN_BITS'(ch);
        r.value = VALUE_BITS'(rest / 15'(SAMPLES - 2));
        r.frame_end = (ch == n - 1);
        expected_means.push_back(r);
      end
      pos = ch + 1;
      if (pos >= n) begin
        pos = 0;
        rnd++;
        if (rnd >= SAMPLES) rnd = 0;
      end
    endfunction

    function void check_result(logic [CHAN_BITS-1:0] ch, logic [VALUE_BITS-1:0] val,
                               logic fe);
      filt_result_t exp_r;
      if (expected_means.size() == 0) begin
        $display("%0t: unexpected result, channel %0d value %0d frame_end %0b",
                 $time, ch, val, fe);
        errors++;
        return;
      end
      exp_r = expected_means.pop_front();
      if (exp_r.channel !== ch) begin
        $display("%0t: channel mismatch, expected %0d, actual %0d", $time, exp_r.channel, ch);
        errors++;
      end
      if (exp_r.value !== val) begin
        $display("%0t: value mismatch, expected %0d, actual %0d", $time, exp_r.value, val);
        errors++;
      end
      if (exp_r.frame_end !== fe) begin
        $display("%0t: frame_end mismatch, expected %0b, actual %0b",
                 $time, exp_r.frame_end, fe);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [SAMPLE_BITS-1:0] sample_i;
  logic                   frame_start_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [CHAN_BITS-1:0]   channel_o;
  logic [VALUE_BITS-1:0]  value_o;
  logic                   frame_end_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_BITS-1:0]    cfg_data_i;

  trimmed_mean_scoreboard sb;
  int unsigned            idle_cycles = 0;
  int unsigned            n_in = 0;
  bit                     burst;
  int                     base [MAX_CHANNELS_DEF];

  multichannel_trimmed_mean_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .channel_o     (channel_o),
    .value_o       (value_o),
    .frame_end_o   (frame_end_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o) ||
                   (cfg_valid_i && cfg_ready_o))) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(channel_o, value_o, frame_end_o);
      end
      if (in_valid_i && !in_stall_o) begin
        sb.note_sample(sample_i, frame_start_i);
        n_in <= n_in + 1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sb.set_channels(cfg_data_i);
      end
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned hold_left;
    int unsigned holds_done;
    int unsigned r;
    stall_left = 0;
    calm_left = 0;
    hold_left = 0;
    holds_done = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && ((holds_done == 0 && n_in >= 500) ||
                             (holds_done == 1 && n_in >= 1300))) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (calm_left > 0) begin
          calm_left--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 3) calm_left = $urandom_range(20, 80);
          else if (r < 8) stall_left = $urandom_range(10, 40);
          else if (r < 35) stall_left = $urandom_range(1, 3);
        end
      end
    end
  end

  function automatic int unsigned next_gap();
    int unsigned r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(int unsigned ch);
    int unsigned r;
    int          v;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    if (r < 50) begin
      v = base[ch] + int'($urandom_range(0, 64)) - 32;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return SAMPLE_BITS'(v);
    end
    return SAMPLE_BITS'($urandom_range(0, 4095));
  endfunction

  task automatic send_sample(logic [SAMPLE_BITS-1:0] s, logic fs);
    int unsigned gap;
    gap = next_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= s;
    frame_start_i <= fs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_channels(logic [CFG_BITS-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    int unsigned k;
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    k = 0;
    while (k < 8) begin
      @(posedge clk_i);
      if (!out_stall_i) k++;
    end
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned         n_sent;
    int unsigned         len;
    int unsigned         r;
    logic                fs;
    logic [CFG_BITS-1:0] cv;
    sb = new();
    burst = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    sample_i = '0;
    frame_start_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    foreach (base[i]) base[i] = 2048;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_channels(3'd1);
    send_sample(12'd0, 1'b1);
    send_sample(12'd4095, 1'b0);
    send_sample(12'd4095, 1'b0);
    send_sample(12'd0, 1'b0);
    send_sample(12'd2048, 1'b0);
    send_sample(12'd1, 1'b0);
    send_sample(12'd4094, 1'b0);
    send_sample(12'd100, 1'b0);
    drain();
    write_channels(3'd0);
    repeat (8) send_sample(12'd4095, 1'b0);
    drain();
    write_channels(3'd2);
    send_sample(12'd5, 1'b1);
    send_sample(12'd6, 1'b0);
    send_sample(12'd7, 1'b0);
    send_sample(12'd8, 1'b0);
    send_sample(12'd4095, 1'b1);
    drain();
    n_sent = 21;

    while (n_sent < TOTAL_SAMPLES) begin
      r = $urandom_range(0, 9);
      case (r)
        0: cv = 3'd0;
        1: cv = 3'd7;
        2: cv = 3'd1;
        3: cv = 3'd6;
        default: cv = CFG_BITS'($urandom_range(0, 7));
      endcase
      write_channels(cv);
      burst = ($urandom_range(0, 4) == 0);
      foreach (base[i]) base[i] = $urandom_range(0, 4095);
      len = $urandom_range(20, 200);
      repeat (len) begin
        if (sb.frame_edge()) fs = ($urandom_range(0, 1) == 1);
        else fs = ($urandom_range(0, 99) == 0);
        if (sb.unsafe()) fs = 1'b1;
        send_sample(pick_sample(sb.next_channel(fs)), fs);
        n_sent++;
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tmf_pkg.sv
src/tmf_stats.sv
src/tmf_div.sv
src/multichannel_trimmed_mean_filter.sv
bench/testbench.sv
